>>> hw/rtl/svsg_pkg.sv
// Shared types and constants of the stepper velocity step generator.
package svsg_pkg;

   localparam int DIVIDEND_W = 48;
   localparam int DIVISOR_W  = 32;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVIDEND_W - 1);

   localparam logic signed [31:0] SENTINEL_Q = 32'sd327680000; // 5000.0 in Q16.16
   localparam logic signed [31:0] VEL_MAX    = 32'sh7fff_ffff;
   localparam logic signed [31:0] VEL_MIN    = 32'sh8000_0000;

   localparam logic [15:0] ACCEL_GAIN_RST      = 16'd655;
   localparam logic [31:0] PERIOD_CONSTANT_RST = 32'd31416;
   localparam logic [23:0] MIN_PERIOD_RST      = 24'd100;
   localparam logic [23:0] MAX_PERIOD_RST      = 24'd1000000;

   typedef enum logic [1:0] {
      ACT_ACCEL = 2'd0,
      ACT_ESTOP = 2'd1,
      ACT_STOP  = 2'd2,
      ACT_TICK  = 2'd3
   } svsg_action_type;

   typedef enum logic [1:0] {
      REG_ACCEL_GAIN      = 2'd0,
      REG_PERIOD_CONSTANT = 2'd1,
      REG_MIN_PERIOD      = 2'd2,
      REG_MAX_PERIOD      = 2'd3
   } svsg_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_FINISH
   } svsg_state_type;

   typedef struct packed {
      logic [15:0] accel_gain;
      logic [31:0] period_constant;
      logic [23:0] min_period;
      logic [23:0] max_period;
   } svsg_cfg_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } svsg_div_cmd_type;

endpackage

>>> hw/rtl/svsg_csr.sv
// Configuration register file behind the APB-style port.
module svsg_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [3:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output svsg_pkg::svsg_cfg_type cfg
);

   svsg_pkg::svsg_cfg_type cfg_ff;
   svsg_pkg::svsg_cfg_type cfg_in;
   svsg_pkg::svsg_reg_type reg_sel;
   logic                   wr_en;

   assign csr_pready = 1'b1;
   assign reg_sel    = svsg_pkg::svsg_reg_type'(csr_paddr[3:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            svsg_pkg::REG_ACCEL_GAIN:      cfg_in.accel_gain      = csr_pwdata[15:0];
            svsg_pkg::REG_PERIOD_CONSTANT: cfg_in.period_constant = csr_pwdata;
            svsg_pkg::REG_MIN_PERIOD:      cfg_in.min_period      = csr_pwdata[23:0];
            svsg_pkg::REG_MAX_PERIOD:      cfg_in.max_period      = csr_pwdata[23:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         svsg_pkg::REG_ACCEL_GAIN:      csr_prdata = {16'd0, cfg_ff.accel_gain};
         svsg_pkg::REG_PERIOD_CONSTANT: csr_prdata = cfg_ff.period_constant;
         svsg_pkg::REG_MIN_PERIOD:      csr_prdata = {8'd0, cfg_ff.min_period};
         svsg_pkg::REG_MAX_PERIOD:      csr_prdata = {8'd0, cfg_ff.max_period};
         default:                       csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.accel_gain      <= svsg_pkg::ACCEL_GAIN_RST;
         cfg_ff.period_constant <= svsg_pkg::PERIOD_CONSTANT_RST;
         cfg_ff.min_period      <= svsg_pkg::MIN_PERIOD_RST;
         cfg_ff.max_period      <= svsg_pkg::MAX_PERIOD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/svsg_divider.sv
// Restoring divider, one quotient bit per cycle.
module svsg_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  svsg_pkg::svsg_div_cmd_type          cmd,
   output logic                                done,
   output logic [svsg_pkg::DIVIDEND_W-1:0]     quotient
);

   logic [svsg_pkg::DIVIDEND_W-1:0] dq_ff, dq_in;
   logic [svsg_pkg::DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [svsg_pkg::DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [svsg_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [svsg_pkg::DIVISOR_W:0]    trial;
   logic                            fits;

   // Bring down the next dividend bit and try the subtraction.
   assign trial = {rem_ff, dq_ff[svsg_pkg::DIVIDEND_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         dq_in   = cmd.dividend;
         rem_in  = '0;
         dvs_in  = cmd.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = svsg_pkg::DIVISOR_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[svsg_pkg::DIVISOR_W-1:0];
         end
         dq_in  = {dq_ff[svsg_pkg::DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == svsg_pkg::DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

>>> hw/rtl/stepper_velocity_step_generator_unit.sv
// Stepper velocity step generator: sequencer, velocity and step state, result port.
// Sequence: a tick, stop or emergency stop goes from IDLE straight to FINISH; an
// acceleration command passes MUL and SUM, and unless it hits the sentinel or lands on zero
// velocity also DIV_START and DIV_WAIT for the 48 one-bit steps of the divider.
// rsp_valid is registered at commit; one request at a time, req_stall high until commit.
// Reset: synchronous, active high; velocity, ticks, position and flags clear, the
// period returns to 1000000 and the registers to their defaults.
module stepper_velocity_step_generator_unit (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic signed [31:0] req_accel,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_enabled,
   output logic               rsp_direction,
   output logic               rsp_step_pulse,
   output logic [23:0]        rsp_step_period,
   output logic signed [31:0] rsp_velocity,
   output logic signed [31:0] rsp_step_position,
   // configuration port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   svsg_pkg::svsg_cfg_type     cfg;
   svsg_pkg::svsg_div_cmd_type div_cmd;
   logic                       div_done;
   logic [svsg_pkg::DIVIDEND_W-1:0] div_quot;

   svsg_pkg::svsg_state_type state_ff, state_in;

   // latched request
   svsg_pkg::svsg_action_type action_ff, action_in;
   logic signed [31:0]        accel_ff, accel_in;

   // working values of an acceleration command
   logic signed [48:0] prod_ff, prod_in;
   logic signed [31:0] sum_ff, sum_in;
   logic               sentinel_ff, sentinel_in;
   logic               zero_ff, zero_in;

   // architectural state; it doubles as the result payload
   logic signed [31:0] vel_ff, vel_in;
   logic [23:0]        period_ff, period_in;
   logic [23:0]        tick_ff, tick_in;
   logic               run_ff, run_in;
   logic               dir_ff, dir_in;
   logic signed [31:0] pos_ff, pos_in;
   logic               pulse_ff, pulse_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               accept;
   logic               slot_free;
   logic               commit;
   logic signed [33:0] sum_wide;
   logic [31:0]        magnitude;
   logic [23:0]        period_clamped;
   logic [24:0]        tick_next;

   svsg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   svsg_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_stall = (state_ff != svsg_pkg::ST_IDLE);
   assign accept    = req_valid & ~req_stall;

   // The state registers are the result, so commit only once the previous
   // result has gone or is leaving this cycle.
   assign slot_free = ~rsp_valid_ff | ~rsp_stall;
   assign commit    = (state_ff == svsg_pkg::ST_FINISH) & slot_free;

   // Velocity plus the gain product floored to Q16.16; dropping the low 16 bits
   // of a two's complement value rounds toward minus infinity.
   assign sum_wide = {{2{vel_ff[31]}}, vel_ff} + {prod_ff[48], prod_ff[48:16]};

   assign magnitude = sum_ff[31] ? 32'(~sum_ff + 32'sd1) : 32'(sum_ff);

   // Clamp the quotient; the minimum check wins when the bounds cross.
   always_comb begin
      if (div_quot <= {24'd0, cfg.min_period}) begin
         period_clamped = cfg.min_period;
      end else if (div_quot >= {24'd0, cfg.max_period}) begin
         period_clamped = cfg.max_period;
      end else begin
         period_clamped = div_quot[23:0];
      end
   end

   assign tick_next = {1'b0, tick_ff} + 25'd1;

   always_comb begin
      div_cmd.start    = (state_ff == svsg_pkg::ST_DIV_START);
      div_cmd.dividend = {cfg.period_constant, 16'd0};
      div_cmd.divisor  = magnitude;
   end

   // Sequencer and commit of the state.
   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      accel_in     = accel_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      sentinel_in  = sentinel_ff;
      zero_in      = zero_ff;
      vel_in       = vel_ff;
      period_in    = period_ff;
      tick_in      = tick_ff;
      run_in       = run_ff;
      dir_in       = dir_ff;
      pos_in       = pos_ff;
      pulse_in     = pulse_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;

      case (state_ff)
         svsg_pkg::ST_IDLE: begin
            if (accept) begin
               action_in = svsg_pkg::svsg_action_type'(req_action);
               accel_in  = req_accel;
               if (svsg_pkg::svsg_action_type'(req_action) == svsg_pkg::ACT_ACCEL) begin
                  state_in = svsg_pkg::ST_MUL;
               end else begin
                  state_in = svsg_pkg::ST_FINISH;
               end
            end
         end
         svsg_pkg::ST_MUL: begin
            prod_in  = $signed({1'b0, cfg.accel_gain}) * accel_ff;
            state_in = svsg_pkg::ST_SUM;
         end
         svsg_pkg::ST_SUM: begin
            // Saturate to the signed 32-bit range.
            if (sum_wide[33:31] == 3'b000 || sum_wide[33:31] == 3'b111) begin
               sum_in = sum_wide[31:0];
            end else if (sum_wide[33]) begin
               sum_in = svsg_pkg::VEL_MIN;
            end else begin
               sum_in = svsg_pkg::VEL_MAX;
            end
            sentinel_in = (accel_ff >= svsg_pkg::SENTINEL_Q);
            zero_in     = (sum_in == 32'sd0);
            if (sentinel_in || zero_in) begin
               state_in = svsg_pkg::ST_FINISH;
            end else begin
               state_in = svsg_pkg::ST_DIV_START;
            end
         end
         svsg_pkg::ST_DIV_START: begin
            state_in = svsg_pkg::ST_DIV_WAIT;
         end
         svsg_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = svsg_pkg::ST_FINISH;
            end
         end
         svsg_pkg::ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               pulse_in     = 1'b0;
               state_in     = svsg_pkg::ST_IDLE;
               case (action_ff)
                  svsg_pkg::ACT_ACCEL: begin
                     if (sentinel_ff) begin
                        vel_in = 32'sd0;
                        run_in = 1'b0;
                     end else if (zero_ff) begin
                        vel_in = sum_ff;
                        run_in = 1'b0;
                     end else begin
                        vel_in    = sum_ff;
                        run_in    = 1'b1;
                        period_in = period_clamped;
                        dir_in    = ~sum_ff[31];
                     end
                  end
                  svsg_pkg::ACT_ESTOP: begin
                     run_in = 1'b0;
                  end
                  svsg_pkg::ACT_STOP: begin
                     vel_in = 32'sd0;
                     run_in = 1'b0;
                  end
                  svsg_pkg::ACT_TICK: begin
                     if (!run_ff) begin
                        tick_in = 24'd0;
                     end else if (tick_next >= {1'b0, period_ff}) begin
                        // Step: reset the count and move one step.
                        pulse_in = 1'b1;
                        tick_in  = 24'd0;
                        pos_in   = dir_ff ? pos_ff + 32'sd1 : pos_ff - 32'sd1;
                     end else begin
                        tick_in = tick_next[23:0];
                     end
                  end
                  default: begin
                     run_in = run_ff;
                  end
               endcase
            end
         end
         default: begin
            state_in = svsg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= svsg_pkg::ST_IDLE;
         vel_ff       <= 32'sd0;
         period_ff    <= svsg_pkg::MAX_PERIOD_RST;
         tick_ff      <= 24'd0;
         run_ff       <= 1'b0;
         dir_ff       <= 1'b0;
         pos_ff       <= 32'sd0;
         pulse_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vel_ff       <= vel_in;
         period_ff    <= period_in;
         tick_ff      <= tick_in;
         run_ff       <= run_in;
         dir_ff       <= dir_in;
         pos_ff       <= pos_in;
         pulse_ff     <= pulse_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working values: no reset, always written before they are read.
   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      accel_ff    <= accel_in;
      prod_ff     <= prod_in;
      sum_ff      <= sum_in;
      sentinel_ff <= sentinel_in;
      zero_ff     <= zero_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_enabled       = run_ff;
   assign rsp_direction     = dir_ff;
   assign rsp_step_pulse    = pulse_ff;
   assign rsp_step_period   = period_ff;
   assign rsp_velocity      = vel_ff;
   assign rsp_step_position = pos_ff;

endmodule

>>> hw/rtl/svsg_checker.sv
// Port-level checks of the step generator and their binding to the top level.
module svsg_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic               rsp_enabled,
   input logic               rsp_direction,
   input logic               rsp_step_pulse,
   input logic signed [31:0] rsp_velocity
);

   // A step only ever comes from a running motor.
   a_pulse_needs_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_step_pulse |-> rsp_enabled)
      else $error("step pulse while disabled");

   // Running implies a nonzero velocity whose sign sets the direction.
   a_enable_matches_velocity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_enabled |-> rsp_velocity != 32'sd0 &&
                                   rsp_direction == !rsp_velocity[31])
      else $error("enable or direction disagrees with velocity");

   // One request at a time: an accepted request blocks the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while the previous one is in flight");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_velocity))
      else $error("stalled result changed");

endmodule

bind stepper_velocity_step_generator_unit svsg_checker u_svsg_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_enabled    (rsp_enabled),
   .rsp_direction  (rsp_direction),
   .rsp_step_pulse (rsp_step_pulse),
   .rsp_velocity   (rsp_velocity)
);
